[hdl/sap_pkg.sv]
`timescale 1ns / 1ps
package sap_pkg;

	localparam int MaxStages = 12;
	localparam int HistDepth = 2 * MaxStages;
	localparam int HistAw = $clog2(HistDepth);
	localparam int StgW = $clog2(MaxStages + 1);

	localparam logic signed [31:0] QOne = 32'sd16777216;
	localparam logic signed [31:0] QMinusOne = -32'sd16777216;

	// register indexes
	localparam logic [2:0] RegBypass = 3'd0;
	localparam logic [2:0] RegFeedback = 3'd1;
	localparam logic [2:0] RegWetMix = 3'd2;
	localparam logic [2:0] RegModScale = 3'd3;
	localparam logic [2:0] RegModOffset = 3'd4;
	localparam logic [2:0] RegStageCount = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_COEF,
		ST_DRY,
		ST_FBK,
		ST_RD,
		ST_STG,
		ST_CLAMP,
		ST_MIX,
		ST_DONE
	} sap_state_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic             prep;
		logic             coef;
		logic             dry;
		logic             fbk;
		logic             rd;
		logic             stg;
		logic             clamp;
		logic             mix;
		logic             bypass;
		logic             ch;
		logic [StgW-1:0]  stage;
	} sap_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

[hdl/sap_ctrl.sv]
`timescale 1ns / 1ps
module sap_ctrl import sap_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            out_busy,
	input  logic            bypass,
	input  logic [3:0]      stage_count,
	output logic            in_ready,
	output logic            res_load,
	output sap_cmd_t        cmd
);

	sap_state_t state_q, state_next;
	logic ch_q;
	logic [StgW-1:0] stage_q;
	logic [StgW-1:0] n_act;

	// clamp count and clear the low bit
	always_comb begin
		if (32'(stage_count) > MaxStages) begin
			n_act = StgW'(MaxStages);
		end else begin
			n_act = StgW'(stage_count);
		end
		n_act[0] = 1'b0;
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) begin
				state_next = bypass ? ST_DONE : ST_PREP;
			end
			ST_PREP: state_next = ST_COEF;
			ST_COEF: state_next = ST_DRY;
			ST_DRY: state_next = ST_FBK;
			ST_FBK: state_next = (n_act == '0) ? ST_CLAMP : ST_RD;
			ST_RD: state_next = ST_STG;
			ST_STG: state_next = (stage_q == StgW'(1)) ? ST_CLAMP : ST_RD;
			ST_CLAMP: state_next = ST_MIX;
			ST_MIX: state_next = ch_q ? ST_DONE : ST_FBK;
			ST_DONE: if (!out_busy) begin
				state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// walk channel and stage counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q <= 1'b0;
			stage_q <= '0;
		end else begin
			state_q <= state_next;
			case (state_q)
				ST_IDLE: ch_q <= 1'b0;
				ST_FBK: stage_q <= n_act;
				ST_STG: stage_q <= stage_q - StgW'(1);
				ST_MIX: ch_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.ch = ch_q;
		cmd.stage = stage_q - StgW'(1);
		cmd.bypass = bypass;
		in_ready = (state_q == ST_IDLE);
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: cmd.load = in_fire;
			ST_PREP: cmd.prep = 1'b1;
			ST_COEF: cmd.coef = 1'b1;
			ST_DRY: cmd.dry = 1'b1;
			ST_FBK: cmd.fbk = 1'b1;
			ST_RD: cmd.rd = 1'b1;
			ST_STG: cmd.stg = 1'b1;
			ST_CLAMP: cmd.clamp = 1'b1;
			ST_MIX: cmd.mix = 1'b1;
			ST_DONE: res_load = !out_busy;
			default: ;
		endcase
	end

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STG |-> 32'(stage_q) <= MaxStages && stage_q != '0)
		else $error("stage counter out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready)
		else $error("ready while busy");
	a_mix_follows_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLAMP |=> state_q == ST_MIX)
		else $error("clamp not followed by mix");

endmodule

[hdl/sap_datapath.sv]
`timescale 1ns / 1ps
module sap_datapath import sap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  sap_cmd_t           cmd,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] right_in,
	input  logic signed [15:0] mod_in,
	input  logic signed [15:0] feedback_gain,
	input  logic [15:0]        wet_mix,
	input  logic signed [15:0] mod_scale,
	input  logic signed [15:0] mod_offset,
	output logic signed [15:0] res_l,
	output logic signed [15:0] res_r
);

	// history memories, one word per channel and stage
	logic [31:0] in_hist_q [HistDepth];
	logic [31:0] out_hist_q [HistDepth];
	logic [HistDepth-1:0] hv_q;
	logic [31:0] rd_in_q, rd_out_q;
	logic rd_v_q;

	logic signed [15:0] l_q, r_q, m_q;
	logic signed [31:0] m01_q, coef_q, dry_l_q, dry_r_q, x_q;
	logic signed [31:0] wet_l_q, wet_r_q;
	logic wv_q;
	logic signed [15:0] fb_abs;
	logic signed [31:0] atten;
	logic [HistAw-1:0] addr;
	logic [15:0] w;

	logic signed [31:0] hin, hout, sum, y, dry_c, wet_c, fdb, chain_in;
	logic signed [63:0] prod;

	// mapping (m+32768)*2^24/65535: q = v*2^24/65535 = v*(2^8 + v')... exact via reciprocal
	logic [16:0] mv;
	logic [49:0] mnum;
	logic [33:0] mq;
	logic [49:0] mrem;

	assign addr = HistAw'(32'(cmd.ch) * MaxStages + 32'(cmd.stage));
	assign hin = rd_v_q ? rd_in_q : 32'sd0;
	assign hout = rd_v_q ? rd_out_q : 32'sd0;
	assign sum = sat32(64'(hout) + 64'(x_q));
	assign fdb = 32'(feedback_gain) <<< 9;
	assign dry_c = cmd.ch ? dry_r_q : dry_l_q;
	// last wet value reads as zero until the first item has been mixed
	assign wet_c = wv_q ? (cmd.ch ? wet_r_q : wet_l_q) : 32'sd0;
	assign fb_abs = feedback_gain[15] ? -feedback_gain : feedback_gain;
	assign atten = QOne - (32'($unsigned(fb_abs)) <<< 7);
	assign w = (wet_mix > 16'd32768) ? 16'd32768 : wet_mix;

	// division of mv*2^24 by 65535 using 1/65535 ~ (2^16+1)/2^32 plus correction
	always_comb begin
		mv = 17'($signed(m_q) + 17'sd32768);
		mnum = {mv, 24'd0} >> 0;
		mq = 34'((mnum + (mnum >> 16)) >> 16);
		mrem = mnum - 50'(mq) * 50'd65535;
		if (mrem >= 50'd65535) begin
			mq = mq + 34'd1;
		end
	end

	// shared multiplier for the coef, dry left, feedback and stage steps, operands chosen by step
	always_comb begin
		prod = '0;
		if (cmd.coef) begin
			prod = 64'(m01_q) * 64'(mod_scale);
		end else if (cmd.dry) begin
			prod = 64'(32'(l_q) <<< 9) * 64'(atten);
		end else if (cmd.fbk) begin
			prod = 64'(wet_c) * 64'(fdb);
		end else if (cmd.stg) begin
			prod = 64'(coef_q) * 64'(sum);
		end
		y = sat32(64'(sat32(prod >>> 24)) - 64'(hin));
		chain_in = sat32(64'(dry_c) + 64'(sat32(prod >>> 24)));
	end

	logic signed [63:0] acc;
	logic signed [63:0] mixv;
	logic signed [63:0] r64;
	always_comb begin
		acc = 64'(dry_c) * (64'sd32768 - 64'(w)) + 64'(x_q) * 64'(w);
		mixv = acc * 64'sd32767;
		r64 = mixv / 64'sd549755813888;
		if (r64 > 64'sd32767) begin
			r64 = 64'sd32767;
		end else if (r64 < -64'sd32768) begin
			r64 = -64'sd32768;
		end
	end

	// history valid bits clear on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= '0;
			rd_v_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				rd_v_q <= hv_q[addr];
			end
			if (cmd.stg) begin
				hv_q[addr] <= 1'b1;
			end
		end
	end

	// memory read and write
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_in_q <= in_hist_q[addr];
			rd_out_q <= out_hist_q[addr];
		end
		if (cmd.stg) begin
			in_hist_q[addr] <= x_q;
			out_hist_q[addr] <= y;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			l_q <= left_in;
			r_q <= right_in;
			m_q <= mod_in;
		end
		if (cmd.prep) begin
			m01_q <= 32'(mq);
		end
		if (cmd.coef) begin
			coef_q <= sat32((prod >>> 15) + 64'(32'(mod_offset) <<< 9));
		end
		if (cmd.dry) begin
			dry_l_q <= sat32(prod >>> 24);
			dry_r_q <= sat32((64'(32'(r_q) <<< 9) * 64'(atten)) >>> 24);
		end
		if (cmd.fbk) begin
			x_q <= chain_in;
		end
		if (cmd.stg) begin
			x_q <= y;
		end
		if (cmd.clamp) begin
			if (x_q > QOne) begin
				x_q <= QOne;
			end else if (x_q < QMinusOne) begin
				x_q <= QMinusOne;
			end
		end
		if (cmd.mix) begin
			if (cmd.ch) begin
				wet_r_q <= x_q;
				res_r <= r64[15:0];
			end else begin
				wet_l_q <= x_q;
				res_l <= r64[15:0];
			end
		end
		if (cmd.load && cmd.bypass) begin
			res_l <= left_in;
			res_r <= right_in;
		end
	end

	// last-wet flag clears on reset, so last wet values read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_q <= 1'b0;
		end else if (cmd.mix && cmd.ch) begin
			wv_q <= 1'b1;
		end
	end

	a_clamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.clamp) |-> x_q <= QOne && x_q >= QMinusOne)
		else $error("wet value outside unit range");
	a_valid_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.stg |=> hv_q[$past(addr)])
		else $error("history entry not marked valid");
	a_wet_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix && cmd.ch |=> wv_q)
		else $error("last wet flag not set");

endmodule

[hdl/stereo_allpass_phaser_top.sv]
`timescale 1ns / 1ps
// Items are taken one at a time: a new item is accepted only after the previous
// result has been loaded into the output register. Processed items run through
// every active stage for each channel; bypass items skip the processing, and
// output stalls delay both.
// Reset: arst_n clears control, registers to defaults and history to zero.
module stereo_allpass_phaser_top import sap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	output logic               ready_in,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] right_in,
	input  logic signed [15:0] mod_in,
	output logic               valid_out,
	input  logic               ready_out,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic bypass_q;
	logic signed [15:0] fb_q, ms_q, mo_q;
	logic [15:0] wm_q;
	logic [3:0] sc_q;
	logic [2:0] ridx;
	logic in_fire, res_load, out_v_q;
	logic signed [15:0] res_l, res_r;
	sap_cmd_t cmd;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];
	assign in_fire = valid_in && ready_in;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			fb_q <= '0;
			wm_q <= 16'd16384;
			ms_q <= 16'sd32767;
			mo_q <= '0;
			sc_q <= 4'd12;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				RegBypass: bypass_q <= pwdata[0];
				RegFeedback: fb_q <= pwdata[15:0];
				RegWetMix: wm_q <= pwdata[15:0];
				RegModScale: ms_q <= pwdata[15:0];
				RegModOffset: mo_q <= pwdata[15:0];
				RegStageCount: sc_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (ridx)
			RegBypass: prdata = {31'd0, bypass_q};
			RegFeedback: prdata = {16'd0, fb_q};
			RegWetMix: prdata = {16'd0, wm_q};
			RegModScale: prdata = {16'd0, ms_q};
			RegModOffset: prdata = {16'd0, mo_q};
			RegStageCount: prdata = {28'd0, sc_q};
			default: prdata = '0;
		endcase
	end

	sap_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(out_v_q),
		.bypass(bypass_q), .stage_count(sc_q), .in_ready(ready_in),
		.res_load(res_load), .cmd(cmd)
	);

	sap_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .left_in(left_in),
		.right_in(right_in), .mod_in(mod_in), .feedback_gain(fb_q),
		.wet_mix(wm_q), .mod_scale(ms_q), .mod_offset(mo_q),
		.res_l(res_l), .res_r(res_r)
	);

	// output register holds the request until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_load) begin
			out_v_q <= 1'b1;
		end else if (ready_out) begin
			out_v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (res_load) begin
			left_out <= res_l;
			right_out <= res_r;
		end
	end
	assign valid_out = out_v_q;

endmodule
